// ===== rtl/tcw_pkg.sv =====
// shared types and constants of the text console character writer
package tcw_pkg;

  localparam int COLUMNS_DEF   = 80;
  localparam int ROWS_DEF      = 25;
  localparam int TAB_WIDTH_DEF = 4;

  localparam int CHAR_W = 8;
  localparam int CCOL_W = 7;
  localparam int CROW_W = 5;

  localparam logic [CHAR_W-1:0] ATTR_RESET   = 8'h07;
  localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_RETURN  = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;

  localparam logic CMD_PUT  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef struct packed {
    logic [CHAR_W-1:0] attr;
    logic [CHAR_W-1:0] chr;
  } cell_t;

  localparam cell_t RESET_CELL = '{attr: ATTR_RESET, chr: CHAR_SPACE};

endpackage

// ===== rtl/text_console_char_writer.sv =====
// text console character writer: cursor sequencer around the screen memory
//
// One command per transaction: put a character at the cursor or read one screen
// cell. Each command returns exactly one result, shown for one cycle with done_o;
// the receiver cannot stall, so it must take the result in that cycle. A read on the
// screen waits in ST_READ for the registered read port; off-screen reads, returns
// and newlines without a scroll finish from ST_IDLE; characters and tabs (up to
// TAB_WIDTH spaces) are written in ST_WRITE. Screen rows live in a ring in memory,
// so a scroll rewrites only the new bottom row, cell by cell through the single
// memory write port. After reset the block clears all ROWS*COLUMNS cells (2000 by
// default) and keeps busy_o high meanwhile; attribute writes are taken at any time.
module text_console_char_writer
  import tcw_pkg::*;
#(
  parameter int COLUMNS   = COLUMNS_DEF,
  parameter int ROWS      = ROWS_DEF,
  parameter int TAB_WIDTH = TAB_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              cmd_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [CROW_W-1:0] read_row_i,
  input  logic [CCOL_W-1:0] read_col_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CHAR_W-1:0] cfg_data_i,
  output logic              done_o,
  output logic [CHAR_W-1:0] cell_char_o,
  output logic [CHAR_W-1:0] cell_attr_o,
  output logic [CCOL_W-1:0] cursor_column_o,
  output logic [CROW_W-1:0] cursor_line_o,
  output logic              did_scroll_o
);

  localparam int DEPTH  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int MOD_W  = $clog2(TAB_WIDTH + 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE,
    ST_SCROLL
  } state_e;

  state_e            state_q, state_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [MOD_W-1:0]  colmod_q, colmod_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ROW_W-1:0]  base_q, base_d;
  logic [MOD_W-1:0]  rem_q, rem_d;
  logic [CHAR_W-1:0] chr_q, chr_d;
  logic              scrolled_q, scrolled_d;
  logic [COL_W-1:0]  fill_q, fill_d;
  logic [ADDR_W-1:0] clr_q, clr_d;
  logic [CHAR_W-1:0] attr_q, attr_d;

  logic              done_q, done_d;
  logic [CHAR_W-1:0] cell_char_q, cell_char_d;
  logic [CHAR_W-1:0] cell_attr_q, cell_attr_d;
  logic [CCOL_W-1:0] cur_col_q, cur_col_d;
  logic [CROW_W-1:0] cur_line_q, cur_line_d;
  logic              did_scroll_q, did_scroll_d;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  cell_t             mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;
  cell_t             mem_rdata;
  logic [ADDR_W-1:0] cur_addr;
  logic              read_in_range;

  // logical row to ring position
  function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                input logic [ROW_W-1:0] b);
    logic [ROW_W:0] sum;
    sum = {1'b0, r} + {1'b0, b};
    if (sum >= (ROW_W+1)'(ROWS)) begin
      sum = sum - (ROW_W+1)'(ROWS);
    end
    return sum[ROW_W-1:0];
  endfunction

  function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] r,
                                                input logic [COL_W-1:0] c);
    return ADDR_W'(ADDR_W'(ADDR_W'(r) * ADDR_W'(COLUMNS)) + ADDR_W'(c));
  endfunction

  tcw_screen_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign cur_addr      = addr_of(phys_row(row_q, base_q), col_q);
  assign read_in_range = (32'(read_row_i) < 32'(ROWS)) && (32'(read_col_i) < 32'(COLUMNS));

  always_comb begin
    state_d      = state_q;
    col_d        = col_q;
    colmod_d     = colmod_q;
    row_d        = row_q;
    base_d       = base_q;
    rem_d        = rem_q;
    chr_d        = chr_q;
    scrolled_d   = scrolled_q;
    fill_d       = fill_q;
    clr_d        = clr_q;
    attr_d       = cfg_valid_i ? cfg_data_i : attr_q;
    done_d       = 1'b0;
    cell_char_d  = cell_char_q;
    cell_attr_d  = cell_attr_q;
    cur_col_d    = cur_col_q;
    cur_line_d   = cur_line_q;
    did_scroll_d = did_scroll_q;
    mem_we       = 1'b0;
    mem_waddr    = cur_addr;
    mem_wdata    = '{attr: attr_q, chr: chr_q};
    mem_re       = 1'b0;
    mem_raddr    = '0;

    case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = RESET_CELL;
        clr_d     = clr_q + 1'b1;
        if (clr_q == ADDR_W'(DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (start_i) begin
          if (cmd_i == CMD_READ) begin
            if (read_in_range) begin
              mem_re    = 1'b1;
              mem_raddr = addr_of(phys_row(ROW_W'(read_row_i), base_q),
                                  COL_W'(read_col_i));
              state_d   = ST_READ;
            end else begin
              done_d       = 1'b1;
              cell_char_d  = '0;
              cell_attr_d  = '0;
              cur_col_d    = CCOL_W'(col_q);
              cur_line_d   = CROW_W'(row_q);
              did_scroll_d = 1'b0;
            end
          end else begin
            case (char_code_i)
              CHAR_NEWLINE: begin
                col_d    = '0;
                colmod_d = '0;
                if (row_q == ROW_W'(ROWS - 1)) begin
                  scrolled_d = 1'b1;
                  rem_d      = '0;
                  fill_d     = '0;
                  state_d    = ST_SCROLL;
                end else begin
                  row_d        = row_q + 1'b1;
                  done_d       = 1'b1;
                  cell_char_d  = '0;
                  cell_attr_d  = '0;
                  cur_col_d    = '0;
                  cur_line_d   = CROW_W'(row_d);
                  did_scroll_d = 1'b0;
                end
              end
              CHAR_RETURN: begin
                col_d        = '0;
                colmod_d     = '0;
                done_d       = 1'b1;
                cell_char_d  = '0;
                cell_attr_d  = '0;
                cur_col_d    = '0;
                cur_line_d   = CROW_W'(row_q);
                did_scroll_d = 1'b0;
              end
              CHAR_TAB: begin
                chr_d      = CHAR_SPACE;
                rem_d      = MOD_W'(TAB_WIDTH) - colmod_q;
                scrolled_d = 1'b0;
                state_d    = ST_WRITE;
              end
              default: begin
                chr_d      = char_code_i;
                rem_d      = MOD_W'(1);
                scrolled_d = 1'b0;
                state_d    = ST_WRITE;
              end
            endcase
          end
        end
      end

      ST_READ: begin
        done_d       = 1'b1;
        cell_char_d  = mem_rdata.chr;
        cell_attr_d  = mem_rdata.attr;
        cur_col_d    = CCOL_W'(col_q);
        cur_line_d   = CROW_W'(row_q);
        did_scroll_d = 1'b0;
        state_d      = ST_IDLE;
      end

      ST_WRITE: begin
        mem_we = 1'b1;
        rem_d  = rem_q - 1'b1;
        if (col_q == COL_W'(COLUMNS - 1)) begin
          col_d    = '0;
          colmod_d = '0;
          if (row_q == ROW_W'(ROWS - 1)) begin
            scrolled_d = 1'b1;
            fill_d     = '0;
            state_d    = ST_SCROLL;
          end else begin
            row_d = row_q + 1'b1;
          end
        end else begin
          col_d    = col_q + 1'b1;
          colmod_d = (colmod_q == MOD_W'(TAB_WIDTH - 1)) ? '0 : colmod_q + 1'b1;
        end
        if (state_d == ST_WRITE && rem_q == MOD_W'(1)) begin
          done_d       = 1'b1;
          cell_char_d  = '0;
          cell_attr_d  = '0;
          cur_col_d    = CCOL_W'(col_d);
          cur_line_d   = CROW_W'(row_d);
          did_scroll_d = scrolled_q;
          state_d      = ST_IDLE;
        end
      end

      ST_SCROLL: begin
        // the oldest ring row becomes the blank bottom row
        mem_we    = 1'b1;
        mem_waddr = addr_of(base_q, fill_q);
        mem_wdata = '{attr: attr_q, chr: CHAR_SPACE};
        fill_d    = fill_q + 1'b1;
        if (fill_q == COL_W'(COLUMNS - 1)) begin
          base_d = (base_q == ROW_W'(ROWS - 1)) ? '0 : base_q + 1'b1;
          if (rem_q != '0) begin
            state_d = ST_WRITE;
          end else begin
            done_d       = 1'b1;
            cell_char_d  = '0;
            cell_attr_d  = '0;
            cur_col_d    = CCOL_W'(col_q);
            cur_line_d   = CROW_W'(row_q);
            did_scroll_d = 1'b1;
            state_d      = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      col_q        <= '0;
      colmod_q     <= '0;
      row_q        <= '0;
      base_q       <= '0;
      rem_q        <= '0;
      chr_q        <= '0;
      scrolled_q   <= 1'b0;
      fill_q       <= '0;
      clr_q        <= '0;
      attr_q       <= ATTR_RESET;
      done_q       <= 1'b0;
      cell_char_q  <= '0;
      cell_attr_q  <= '0;
      cur_col_q    <= '0;
      cur_line_q   <= '0;
      did_scroll_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      col_q        <= col_d;
      colmod_q     <= colmod_d;
      row_q        <= row_d;
      base_q       <= base_d;
      rem_q        <= rem_d;
      chr_q        <= chr_d;
      scrolled_q   <= scrolled_d;
      fill_q       <= fill_d;
      clr_q        <= clr_d;
      attr_q       <= attr_d;
      done_q       <= done_d;
      cell_char_q  <= cell_char_d;
      cell_attr_q  <= cell_attr_d;
      cur_col_q    <= cur_col_d;
      cur_line_q   <= cur_line_d;
      did_scroll_q <= did_scroll_d;
    end
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign done_o          = done_q;
  assign cell_char_o     = cell_char_q;
  assign cell_attr_o     = cell_attr_q;
  assign cursor_column_o = cur_col_q;
  assign cursor_line_o   = cur_line_q;
  assign did_scroll_o    = did_scroll_q;

endmodule

// ===== rtl/tcw_screen_ram.sv =====
// screen cell memory, one write port and one registered read port
module tcw_screen_ram
  import tcw_pkg::*;
#(
  parameter int DEPTH  = ROWS_DEF * COLUMNS_DEF,
  parameter int ADDR_W = $clog2(ROWS_DEF * COLUMNS_DEF)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  cell_t             wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output cell_t             rdata_o
);

  cell_t mem_q [DEPTH];
  cell_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sim/tb_text_console_char_writer.sv =====
// testbench of the text console character writer: directed and random command streams
module tb_text_console_char_writer;
  import tcw_pkg::*;

  localparam int COLUMNS      = COLUMNS_DEF;
  localparam int ROWS         = ROWS_DEF;
  localparam int TAB_WIDTH    = TAB_WIDTH_DEF;
  localparam int MAX_GAP      = 16;
  localparam int DRAIN_CYCLES = 8;
  localparam int RESET_CYCLES = 7;

  typedef enum int {MIX_TEXT, MIX_LONG_LINES, MIX_READS} stream_mix_e;

  typedef struct packed {
    logic [CHAR_W-1:0] chr;
    logic [CHAR_W-1:0] attr;
    logic [CCOL_W-1:0] col;
    logic [CROW_W-1:0] row;
    logic              scrolled;
  } console_result_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              start_i     = 1'b0;
  logic              cmd_i       = CMD_PUT;
  logic [CHAR_W-1:0] char_code_i = '0;
  logic [CROW_W-1:0] read_row_i  = '0;
  logic [CCOL_W-1:0] read_col_i  = '0;
  logic              cfg_valid_i = 1'b0;
  logic [CHAR_W-1:0] cfg_data_i  = '0;
  logic              busy_o;
  logic              cfg_ready_o;
  logic              done_o;
  logic [CHAR_W-1:0] cell_char_o;
  logic [CHAR_W-1:0] cell_attr_o;
  logic [CCOL_W-1:0] cursor_column_o;
  logic [CROW_W-1:0] cursor_line_o;
  logic              did_scroll_o;

  // shadow copy of the console
  cell_t             screen_mem [ROWS*COLUMNS];
  int                cursor_col;
  int                cursor_row;
  logic [CHAR_W-1:0] text_attr;

  console_result_t   result_q [$];
  bit                idle_on;
  int                error_count;
  int                item_count;
  int                read_count;
  int                scroll_count;
  int                attr_count;

  text_console_char_writer i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .char_code_i    (char_code_i),
    .read_row_i     (read_row_i),
    .read_col_i     (read_col_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .cell_char_o    (cell_char_o),
    .cell_attr_o    (cell_attr_o),
    .cursor_column_o(cursor_column_o),
    .cursor_line_o  (cursor_line_o),
    .did_scroll_o   (did_scroll_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit advance_line();
    int i;
    cursor_col = 0;
    cursor_row++;
    if (cursor_row < ROWS) return 1'b0;
    for (i = 0; i < (ROWS - 1) * COLUMNS; i++) screen_mem[i] = screen_mem[i + COLUMNS];
    for (i = 0; i < COLUMNS; i++) begin
      screen_mem[(ROWS - 1) * COLUMNS + i] = '{attr: text_attr, chr: CHAR_SPACE};
    end
    if (cursor_row > 0) cursor_row--;
    return 1'b1;
  endfunction

  function automatic bit store_char(logic [CHAR_W-1:0] ch);
    if (cursor_row < ROWS && cursor_col < COLUMNS) begin
      screen_mem[cursor_row * COLUMNS + cursor_col] = '{attr: text_attr, chr: ch};
    end
    cursor_col++;
    if (cursor_col >= COLUMNS) return advance_line();
    return 1'b0;
  endfunction

  function automatic console_result_t predict_result(logic cmd, logic [CHAR_W-1:0] ch,
                                                     logic [CROW_W-1:0] rr,
                                                     logic [CCOL_W-1:0] rc);
    console_result_t res;
    int              idx;
    int              spaces;
    res = '0;
    if (cmd == CMD_READ) begin
      if (rr < ROWS && rc < COLUMNS) begin
        idx = int'(rr) * COLUMNS + int'(rc);
        res.chr = screen_mem[idx].chr;
        res.attr = screen_mem[idx].attr;
      end
    end else if (ch == CHAR_NEWLINE) begin
      res.scrolled = advance_line();
    end else if (ch == CHAR_RETURN) begin
      cursor_col = 0;
    end else if (ch == CHAR_TAB) begin
      spaces = TAB_WIDTH - (cursor_col % TAB_WIDTH);
      repeat (spaces) if (store_char(CHAR_SPACE)) res.scrolled = 1'b1;
    end else begin
      res.scrolled = store_char(ch);
    end
    res.col = cursor_col[CCOL_W-1:0];
    res.row = cursor_row[CROW_W-1:0];
    return res;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    console_result_t want;
    if (rst_ni && done_o) begin
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0h/%0h %0d:%0d scroll %0b",
                 $time, cell_char_o, cell_attr_o, cursor_column_o, cursor_line_o,
                 did_scroll_o);
        error_count++;
      end else begin
        want = result_q.pop_front();
        check_field("cell_char", want.chr, cell_char_o);
        check_field("cell_attr", want.attr, cell_attr_o);
        check_field("cursor_column", want.col, cursor_column_o);
        check_field("cursor_line", want.row, cursor_line_o);
        check_field("did_scroll", want.scrolled, did_scroll_o);
        if (want.scrolled) scroll_count++;
      end
    end
  end

  // start stays high across back-to-back transactions
  task automatic send_command(logic cmd, logic [CHAR_W-1:0] ch, logic [CROW_W-1:0] rr,
                              logic [CCOL_W-1:0] rc);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i     <= 1'b1;
    cmd_i       <= cmd;
    char_code_i <= ch;
    read_row_i  <= rr;
    read_col_i  <= rc;
    do @(posedge clk_i); while (busy_o);
    result_q.push_back(predict_result(cmd, ch, rr, rc));
    item_count++;
    if (cmd == CMD_READ) read_count++;
  endtask

  task automatic put_char(logic [CHAR_W-1:0] ch);
    send_command(CMD_PUT, ch, CROW_W'($urandom), CCOL_W'($urandom));
  endtask

  task automatic read_cell(int rr, int rc);
    send_command(CMD_READ, CHAR_W'($urandom), CROW_W'(rr), CCOL_W'(rc));
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    while (result_q.size() > 0) @(posedge clk_i);
  endtask

  task automatic write_attribute(logic [CHAR_W-1:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    text_attr = value;
    attr_count++;
  endtask

  task automatic random_stream(int count, stream_mix_e mix);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      case (mix)
        MIX_TEXT: begin
          if (pick < 50) put_char(CHAR_W'($urandom_range(0, 255)));
          else if (pick < 70) put_char(CHAR_NEWLINE);
          else if (pick < 75) put_char(CHAR_RETURN);
          else if (pick < 85) put_char(CHAR_TAB);
          else pick = -1;
        end
        MIX_LONG_LINES: begin
          if (pick < 55) put_char(CHAR_W'($urandom_range(0, 255)));
          else if (pick < 95) put_char(CHAR_TAB);
          else pick = -1;
        end
        default: begin
          if (pick < 35) put_char(CHAR_W'($urandom_range(0, 255)));
          else if (pick < 45) put_char(CHAR_NEWLINE);
          else if (pick < 50) put_char(CHAR_RETURN);
          else if (pick < 60) put_char(CHAR_TAB);
          else pick = -1;
        end
      endcase
      // reads mostly land on the screen, some go past its edges
      if (pick < 0) begin
        read_cell(($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                              : $urandom_range(0, ROWS - 1),
                  ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                              : $urandom_range(0, COLUMNS - 1));
      end
    end
  endtask

  task automatic test_reset_screen();
    idle_on = 1'b0;
    read_cell(0, 0);
    read_cell(ROWS - 1, COLUMNS - 1);
    read_cell(ROWS, 0);
    read_cell(0, COLUMNS);
    read_cell(31, 127);
  endtask

  task automatic test_put_and_control();
    idle_on = 1'b1;
    put_char(8'h41);
    put_char(8'h00);
    put_char(8'hFF);
    put_char(CHAR_TAB);   // one space up to column 4
    put_char(CHAR_TAB);   // a full tab stop
    put_char(CHAR_RETURN);
    put_char(CHAR_NEWLINE);
    put_char(8'h7E);
    read_cell(0, 0);
    read_cell(0, 2);
    read_cell(0, 7);
    read_cell(1, 0);
  endtask

  task automatic test_attribute_extremes();
    write_attribute(8'h00);
    put_char(8'h5A);
    write_attribute(8'hFF);
    put_char(8'hA5);
    read_cell(1, 1);
    read_cell(1, 2);
  endtask

  task automatic test_random_text();
    write_attribute(CHAR_W'($urandom));
    idle_on = 1'b1;
    random_stream(150, MIX_TEXT);
  endtask

  task automatic test_random_long_lines();
    write_attribute(CHAR_W'($urandom));
    idle_on = 1'b0;
    random_stream(75, MIX_LONG_LINES);
    idle_on = 1'b1;
    random_stream(75, MIX_LONG_LINES);
  endtask

  task automatic test_random_reads();
    write_attribute(ATTR_RESET);
    idle_on = 1'b1;
    random_stream(100, MIX_READS);
    idle_on = 1'b0;
    random_stream(50, MIX_READS);
  endtask

  initial begin
    for (int i = 0; i < ROWS * COLUMNS; i++) screen_mem[i] = RESET_CELL;
    text_attr    = ATTR_RESET;
    cursor_col   = 0;
    cursor_row   = 0;
    idle_on      = 1'b0;
    error_count  = 0;
    item_count   = 0;
    read_count   = 0;
    scroll_count = 0;
    attr_count   = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_screen();
    test_put_and_control();
    test_attribute_extremes();
    test_random_text();
    test_random_long_lines();
    test_random_reads();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("ran %0d commands, %0d of them cell reads, %0d results with a scroll,",
             item_count, read_count, scroll_count);
    $display("under %0d attribute writes including both extreme values", attr_count);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tcw_pkg.sv
rtl/tcw_screen_ram.sv
rtl/text_console_char_writer.sv
sim/tb_text_console_char_writer.sv
